// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside of reset.
`define SBC_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition never holds outside of reset.
`define SBC_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define SBC_ASSERT(name, clk, rst_n, prop)
`define SBC_NEVER(name, clk, rst_n, cond)

`endif

`endif

// ===== hdl/sha256bc_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 compression package
// Word type, round constants, initial hash and the sigma functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256bc_pkg;

    typedef logic [31:0] word_t;

    localparam int unsigned BLOCK_WORDS  = 16;
    localparam int unsigned ROUND_COUNT  = 64;
    localparam int unsigned DIGEST_WORDS = 8;

    localparam word_t ROUND_K [ROUND_COUNT] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t INITIAL_HASH [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sha256_block_compression_core.sv =====
// ----------------------------------------------------------------------------
// SHA-256 block compression core
// Collects sixteen message words per block, runs 64 rounds on one shared
// round unit, folds the result into the chaining hash and emits the digest.
// ----------------------------------------------------------------------------
// Sequence: a block's sixteenth beat starts the rounds, then a feed-forward
//   step folds them into the hash; after a last block the digest streams out.
// Throughput: one round per cycle on the single round unit; no message beat
//   is taken during the rounds, the feed-forward or the eight digest beats.
// Reset: synchronous, active low; the hash loads the standard initial values,
//   working variables and counters clear, the schedule window is not cleared.
`default_nettype none

`include "assert_macros.svh"

module sha256_block_compression_core
    import sha256bc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_message_word,
    input  wire logic        s_first_block,
    input  wire logic        s_last_block,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_digest_index,
    output logic             m_digest_last
);

    // Sequencer states.
    localparam logic [1:0] ST_LOAD  = 2'd0;  // take message beats
    localparam logic [1:0] ST_ROUND = 2'd1;  // one compression round per cycle
    localparam logic [1:0] ST_FEED  = 2'd2;  // add working vars into the hash
    localparam logic [1:0] ST_EMIT  = 2'd3;  // stream out the digest

    logic [1:0] state_reg, state_next;
    logic [3:0] word_cnt_reg, word_cnt_next;
    logic [5:0] round_cnt_reg, round_cnt_next;
    logic [2:0] out_idx_reg, out_idx_next;
    logic       last_reg, last_next;

    word_t hash_reg [DIGEST_WORDS];
    word_t hash_next [DIGEST_WORDS];
    word_t work_reg [DIGEST_WORDS];
    word_t work_next [DIGEST_WORDS];

    // Rolling schedule window: entry 0 is W[t], entry 15 is W[t+15].
    word_t win_reg [BLOCK_WORDS];
    word_t win_next [BLOCK_WORDS];

    logic s_fire;
    logic m_fire;

    // Round unit and schedule expansion.
    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;
    word_t sched_new;

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = (state_reg == ST_EMIT);
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;

    assign m_digest_word  = hash_reg[out_idx_reg];
    assign m_digest_index = out_idx_reg;
    assign m_digest_last  = (out_idx_reg == 3'(DIGEST_WORDS - 1));

    // work: a=0 b=1 c=2 d=3 e=4 f=5 g=6 h=7
    assign ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
    assign t1  = work_reg[7] + big_sigma1(work_reg[4]) + ch
               + ROUND_K[round_cnt_reg] + win_reg[0];
    assign t2  = big_sigma0(work_reg[0]) + maj;

    // W[t+16] from the current window; values computed from round 48 on go unused.
    assign sched_new = small_sigma1(win_reg[14]) + win_reg[9]
                     + small_sigma0(win_reg[1]) + win_reg[0];

    always_comb begin
        state_next     = state_reg;
        word_cnt_next  = word_cnt_reg;
        round_cnt_next = round_cnt_reg;
        out_idx_next   = out_idx_reg;
        last_next      = last_reg;
        for (int i = 0; i < DIGEST_WORDS; i++) begin
            hash_next[i] = hash_reg[i];
            work_next[i] = work_reg[i];
        end
        for (int i = 0; i < BLOCK_WORDS; i++) begin
            win_next[i] = win_reg[i];
        end

        case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    // Shift the new beat into the top of the window.
                    for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                        win_next[i] = win_reg[i + 1];
                    end
                    win_next[BLOCK_WORDS - 1] = s_message_word;
                    word_cnt_next = word_cnt_reg + 4'd1;
                    // First-block flag counts only on a block's first beat.
                    if (word_cnt_reg == 4'd0 && s_first_block) begin
                        for (int i = 0; i < DIGEST_WORDS; i++) begin
                            hash_next[i] = INITIAL_HASH[i];
                        end
                    end
                    // Sixteenth beat: seed a..h and start the rounds.
                    if (word_cnt_reg == 4'(BLOCK_WORDS - 1)) begin
                        last_next      = s_last_block;
                        round_cnt_next = '0;
                        for (int i = 0; i < DIGEST_WORDS; i++) begin
                            work_next[i] = hash_reg[i];
                        end
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
                // Advance the schedule window by one word.
                for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[BLOCK_WORDS - 1] = sched_new;
                round_cnt_next = round_cnt_reg + 6'd1;
                if (round_cnt_reg == 6'(ROUND_COUNT - 1)) begin
                    state_next = ST_FEED;
                end
            end
            ST_FEED: begin
                for (int i = 0; i < DIGEST_WORDS; i++) begin
                    hash_next[i] = hash_reg[i] + work_reg[i];
                end
                out_idx_next = '0;
                state_next   = last_reg ? ST_EMIT : ST_LOAD;
            end
            ST_EMIT: begin
                if (m_fire) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'(DIGEST_WORDS - 1)) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            word_cnt_reg  <= '0;
            round_cnt_reg <= '0;
            out_idx_reg   <= '0;
            last_reg      <= 1'b0;
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                hash_reg[i] <= INITIAL_HASH[i];
                work_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            word_cnt_reg  <= word_cnt_next;
            round_cnt_reg <= round_cnt_next;
            out_idx_reg   <= out_idx_next;
            last_reg      <= last_next;
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                hash_reg[i] <= hash_next[i];
                work_reg[i] <= work_next[i];
            end
        end
    end

    // Schedule window holds payload only; no reset.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < BLOCK_WORDS; i++) begin
            win_reg[i] <= win_next[i];
        end
    end

    // Input and output sides are never open together.
    `SBC_NEVER(a_ready_and_valid, aclk, aresetn, s_ready && m_valid)
    // The sixteenth beat starts round zero.
    `SBC_ASSERT(a_block_starts_rounds, aclk, aresetn, (s_fire && word_cnt_reg == 4'd15) |=> (state_reg == ST_ROUND && round_cnt_reg == 6'd0))
    // The final round hands over to the feed-forward state.
    `SBC_ASSERT(a_rounds_end, aclk, aresetn, (state_reg == ST_ROUND && round_cnt_reg == 6'd63) |=> (state_reg == ST_FEED))
    // No digest beat follows the one marked last.
    `SBC_ASSERT(a_digest_closes, aclk, aresetn, (m_fire && m_digest_last) |=> (!m_valid && word_cnt_reg == 4'd0))

endmodule

`default_nettype wire

// ===== tb/sha256_block_compression_core_tb.sv =====
// ----------------------------------------------------------------------------
// SHA-256 block compression core testbench
// Streams message words into the core over valid/ready and predicts
// every digest beat with an independent SHA-256 compression. Each digest beat
// is compared field by field against the oldest predicted beat, with random
// idling on both channels and a final drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sha256_block_compression_core_tb;

    import sha256bc_pkg::*;

    // One predicted digest beat, in the order the core must emit them.
    typedef struct packed {
        word_t      word;
        logic [2:0] index;
        logic       last;
    } digest_beat_t;

    // ------------------------------------------------------------------------
    // Digest tracker: mirrors the chaining hash, the word window of the
    // current block and the word position, and holds the digest beats due.
    // ------------------------------------------------------------------------
    class digest_tracker;
        word_t          chain [DIGEST_WORDS];
        word_t          window [BLOCK_WORDS];
        int unsigned    word_pos;
        digest_beat_t   beats_due [$];
        int unsigned    errors;

        function new();
            chain    = INITIAL_HASH;
            word_pos = 0;
            errors   = 0;
            foreach (window[i]) window[i] = '0;
        endfunction

        // Rotate right by n, built from a doubled word.
        function word_t spin(word_t x, int unsigned n);
            logic [63:0] twice;
            twice = {x, x} >> n;
            return twice[31:0];
        endfunction

        // Run the 64 rounds on the collected window and fold into the chain.
        function void fold_block();
            word_t sched [ROUND_COUNT];
            word_t v [DIGEST_WORDS];
            word_t lo, hi, t1, t2;
            for (int t = 0; t < ROUND_COUNT; t++) begin
                if (t < BLOCK_WORDS) begin
                    sched[t] = window[t];
                end else begin
                    lo = sched[t-15];
                    hi = sched[t-2];
                    sched[t] = (spin(hi, 17) ^ spin(hi, 19) ^ (hi >> 10)) + sched[t-7]
                             + (spin(lo, 7) ^ spin(lo, 18) ^ (lo >> 3)) + sched[t-16];
                end
            end
            v = chain;
            for (int t = 0; t < ROUND_COUNT; t++) begin
                t1 = v[7] + (spin(v[4], 6) ^ spin(v[4], 11) ^ spin(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + sched[t];
                t2 = (spin(v[0], 2) ^ spin(v[0], 13) ^ spin(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            foreach (chain[k]) chain[k] = chain[k] + v[k];
        endfunction

        // Note one accepted message beat; queue the digest after a last block.
        function void note_word(word_t w, logic first_f, logic last_f);
            digest_beat_t beat;
            if (word_pos == 0 && first_f) chain = INITIAL_HASH;
            window[word_pos] = w;
            if (word_pos != BLOCK_WORDS - 1) begin
                word_pos++;
                return;
            end
            word_pos = 0;
            fold_block();
            if (!last_f) return;
            for (int k = 0; k < DIGEST_WORDS; k++) begin
                beat.word  = chain[k];
                beat.index = 3'(k);
                beat.last  = (k == DIGEST_WORDS - 1);
                beats_due.push_back(beat);
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        // Compare one accepted digest beat against the oldest prediction.
        task check_digest(word_t w, logic [2:0] idx, logic lst);
            digest_beat_t due;
            if (beats_due.size() == 0) begin
                report_mismatch($sformatf("unexpected digest beat %h idx %0d", w, idx));
                return;
            end
            due = beats_due.pop_front();
            if (w !== due.word)
                report_mismatch($sformatf("digest_word %h, want %h", w, due.word));
            if (idx !== due.index)
                report_mismatch($sformatf("digest_index %0d, want %0d", idx, due.index));
            if (lst !== due.last)
                report_mismatch($sformatf("digest_last %b, want %b", lst, due.last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block connections
    // ------------------------------------------------------------------------
    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [31:0] s_message_word = '0;
    logic        s_first_block  = 1'b0;
    logic        s_last_block   = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_digest_index;
    logic        m_digest_last;

    // Idle odds, in percent per cycle, for each side of the core.
    int unsigned tx_idle_pct = 7;
    int unsigned rx_idle_pct = 83;
    int unsigned words_sent  = 0;

    digest_tracker tracker = new();

    sha256_block_compression_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message_word (s_message_word),
        .s_first_block  (s_first_block),
        .s_last_block   (s_last_block),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digest_word  (m_digest_word),
        .m_digest_index (m_digest_index),
        .m_digest_last  (m_digest_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the core hangs; the slowest correct run is far shorter.
    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Digest side: check the beat taken at each edge, then pick the next
    // ready level. Ready is driven once per edge.
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                tracker.check_digest(m_digest_word, m_digest_index, m_digest_last);
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Message side
    // ------------------------------------------------------------------------

    // Offer one message beat and hold it until the core takes it. Idle cycles
    // go in front of the beat only, so valid never drops while it waits.
    task automatic send_word(input word_t w, input logic first_f, input logic last_f);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_message_word <= w;
        s_first_block  <= first_f;
        s_last_block   <= last_f;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_word(w, first_f, last_f);
        words_sent++;
    endtask

    // Hold off the sender until every predicted digest beat has come back.
    task automatic hold_for_digests();
        s_valid <= 1'b0;
        while (tracker.beats_due.size() != 0) @(posedge aclk);
    endtask

    // Mostly random words, with the all-zero and all-one extremes mixed in.
    function automatic word_t pick_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Send one sixteen-word block. The start flag counts only on the first
    // word and the end flag only on the sixteenth; elsewhere they are noise.
    task automatic send_block(input logic first_f, input logic last_f);
        for (int i = 0; i < BLOCK_WORDS; i++) begin
            send_word(pick_word(),
                      (i == 0) ? first_f : logic'($urandom_range(1)),
                      (i == BLOCK_WORDS - 1) ? last_f : logic'($urandom_range(1)));
        end
    endtask

    initial begin
        int unsigned n_blocks;
        int unsigned wait_cycles;
        logic        first_f;
        logic        last_f;

        // Hold reset from the start, then release it once.
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed block right after reset with no start flag on its first
        // word: it must chain from the reset hash. Both flags are set on the
        // wrong words, and the words swing between the field extremes.
        for (int i = 0; i < BLOCK_WORDS; i++) begin
            send_word((i % 4 == 0) ? 32'h0000_0000 :
                      (i % 4 == 1) ? 32'hffff_ffff :
                      (i % 4 == 2) ? 32'h8000_0000 : 32'h0000_0001,
                      (i != 0),
                      (i == BLOCK_WORDS - 1) || (i % 3 == 1));
        end
        hold_for_digests();

        // Random messages of one to three blocks. Most start with the start
        // flag and end with the end flag; some skip the start flag (chaining
        // on from the previous digest) or lose the end flag.
        while (words_sent < 16 + 88) begin
            if (words_sent >= 40 && tx_idle_pct == 7) begin
                // Swap the idle odds of the two sides.
                hold_for_digests();
                tx_idle_pct = 83;
                rx_idle_pct = 7;
            end else if (words_sent >= 72 && tx_idle_pct == 83) begin
                // No idling from here on.
                hold_for_digests();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            n_blocks = $urandom_range(1, 3);
            for (int b = 0; b < n_blocks; b++) begin
                first_f = (b == 0) ? ($urandom_range(7) != 0) : ($urandom_range(7) == 0);
                last_f  = (b == n_blocks - 1) ? ($urandom_range(9) != 0)
                                              : ($urandom_range(9) == 0);
                send_block(first_f, last_f);
            end
        end
        s_valid <= 1'b0;

        // Drain the digest beats still due, then let the core settle.
        wait_cycles = 0;
        while (tracker.beats_due.size() != 0 && wait_cycles < 5000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (100) @(posedge aclk);
        if (tracker.beats_due.size() != 0)
            tracker.report_mismatch($sformatf("%0d digest beats never arrived",
                                              tracker.beats_due.size()));

        if (tracker.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
